FILE: hdl/cdeq_pkg.sv
// Package for the circular double-ended queue.
// Holds the widths, request and status codes and the cell command type.
// No dependencies.
`default_nettype none

package cdeq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_BACK  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                     shift_up;
        logic                     shift_down;
        logic                     append;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/cdeq_if.sv
// Request and response channel interfaces of the double-ended queue.
// Depends on cdeq_pkg.
`default_nettype none

interface cdeq_req_if;
    logic                               valid;
    logic                               ready;
    logic [cdeq_pkg::MODE_W-1:0]        mode;
    logic signed [cdeq_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink (input valid, input mode, input item_value, output ready);
endinterface

interface cdeq_rsp_if #(
    parameter int CountWidth = cdeq_pkg::COUNT_W_DEFAULT
);
    logic                               valid;
    logic                               ready;
    logic signed [cdeq_pkg::DATA_W-1:0] read_value;
    logic [cdeq_pkg::STATUS_W-1:0]      status;
    logic [CountWidth-1:0]              entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/cdeq_cell.sv
// One storage cell of the queue chain, holding a single entry.
// Depends on cdeq_pkg; instantiated by circular_double_ended_queue.
`default_nettype none

module cdeq_cell #(
    parameter int CountWidth = cdeq_pkg::COUNT_W_DEFAULT,
    parameter int Index      = 0
) (
    input  wire logic                               clk,
    input  wire cdeq_pkg::cell_cmd_t                cmd,
    input  wire logic [CountWidth-1:0]              count,
    input  wire logic signed [cdeq_pkg::DATA_W-1:0] prev_data,
    input  wire logic signed [cdeq_pkg::DATA_W-1:0] next_data,
    output logic signed [cdeq_pkg::DATA_W-1:0]      data
);

    localparam logic [CountWidth-1:0] MyIndex = CountWidth'(Index);

    logic signed [cdeq_pkg::DATA_W-1:0] data_reg;
    logic signed [cdeq_pkg::DATA_W-1:0] data_next;

    // The front of the queue sits in cell zero; entries move up on a push at the
    // front and down on a pop at the front.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            data_next = prev_data;
        end
        else if (cmd.shift_down)
        begin
            data_next = next_data;
        end
        else if (cmd.append && (count == MyIndex))
        begin
            data_next = cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: hdl/circular_double_ended_queue.sv
// Double-ended queue built as a chain of storage cells with front at cell zero.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while results drain; no op needs two cell updates.
// A request is taken whenever the result register is empty or being emptied.
// Reset empties the queue and the result register; entry contents are not cleared.
// Depends on cdeq_pkg, cdeq_if and cdeq_cell.
`default_nettype none

module circular_double_ended_queue #(
    parameter int Depth      = cdeq_pkg::DEPTH_DEFAULT,
    parameter int CountWidth = $clog2(Depth + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cdeq_req_if.sink  req,
    cdeq_rsp_if.source rsp
);

    localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

    logic signed [cdeq_pkg::DATA_W-1:0] cell_data [Depth];
    cdeq_pkg::cell_cmd_t                cmd;

    logic [CountWidth-1:0]              count_reg;
    logic [CountWidth-1:0]              count_next;
    logic                               out_valid_reg;
    logic signed [cdeq_pkg::DATA_W-1:0] read_reg;
    logic signed [cdeq_pkg::DATA_W-1:0] read_next;
    cdeq_pkg::status_t                  status_reg;
    cdeq_pkg::status_t                  status_next;
    logic [CountWidth-1:0]              out_count_reg;

    logic                               accept;
    logic                               is_empty;
    logic                               is_full;
    logic signed [cdeq_pkg::DATA_W-1:0] back_value;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FullCount);

    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        logic signed [cdeq_pkg::DATA_W-1:0] prev_d;
        logic signed [cdeq_pkg::DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = cmd.value;
        end
        else
        begin : g_inner
            assign prev_d = cell_data[i-1];
        end

        if (i == Depth - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_notlast
            assign next_d = cell_data[i+1];
        end

        cdeq_cell #(
            .CountWidth (CountWidth),
            .Index      (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .count     (count_reg),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    // The back entry lives in the cell just below the occupancy count.
    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < Depth; i++)
        begin
            if (count_reg == CountWidth'(i + 1))
            begin
                back_value = back_value | cell_data[i];
            end
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.value      = req.item_value;
        count_next     = count_reg;
        read_next      = '0;
        status_next    = cdeq_pkg::ST_OK;
        if (accept)
        begin
            case (cdeq_pkg::mode_t'(req.mode))
                cdeq_pkg::MODE_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = cdeq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.shift_up = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                cdeq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = cdeq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                cdeq_pkg::MODE_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = cdeq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_next      = cell_data[0];
                        cmd.shift_down = 1'b1;
                        count_next     = count_reg - 1'b1;
                    end
                end
                cdeq_pkg::MODE_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = cdeq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_next  = back_value;
                        count_next = count_reg - 1'b1;
                    end
                end
                cdeq_pkg::MODE_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = cdeq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_next = cell_data[0];
                    end
                end
                cdeq_pkg::MODE_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = cdeq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_next = back_value;
                    end
                end
                default:
                begin
                    status_next = cdeq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_reg      <= read_next;
            status_reg    <= status_next;
            out_count_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = read_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = out_count_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCount)
        else $error("Occupancy exceeds the queue depth.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == cdeq_pkg::ST_FULL)) |-> (rsp.entry_count == FullCount))
        else $error("Full status reported while the queue is not full.");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == cdeq_pkg::ST_EMPTY)) |-> (rsp.entry_count == '0))
        else $error("Empty status reported while the queue holds entries.");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.valid && (rsp.entry_count == count_reg)))
        else $error("Reported occupancy differs from the held count.");

endmodule

`default_nettype wire
